@@ src/lztd_pkg.sv @@
// Shared constants and types for the LZ77 token decompressor.
`default_nettype none

package lztd_pkg;

  localparam int unsigned WINDOW_BYTES = 32768;
  localparam int unsigned GROUP_BYTES  = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned DIST_W       = 15;
  localparam int unsigned LEN_W        = 8;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned SLOT_W       = $clog2(GROUP_BYTES);

  typedef struct packed {
    logic [GROUP_BYTES-1:0][BYTE_W-1:0] data;
    logic [CNT_W-1:0]                   count;
    logic                               last;
    logic                               err;
    logic [TOTAL_W-1:0]                 total;
  } res_t;

endpackage

`default_nettype wire

@@ src/lztd_if.sv @@
// Token and result channel interfaces.
`default_nettype none

interface lztd_tok_if;
  logic                          valid;
  logic                          ready;
  logic                          is_match;
  logic [lztd_pkg::BYTE_W-1:0]   literal_byte;
  logic [lztd_pkg::DIST_W-1:0]   back_distance;
  logic [lztd_pkg::LEN_W-1:0]    copy_length;

  modport source (output valid, is_match, literal_byte, back_distance, copy_length,
                  input ready);
  modport sink (input valid, is_match, literal_byte, back_distance, copy_length,
                output ready);
endinterface

interface lztd_res_if;
  logic                          valid;
  logic                          ready;
  logic [lztd_pkg::BYTE_W-1:0]   first_byte;
  logic [lztd_pkg::BYTE_W-1:0]   second_byte;
  logic [lztd_pkg::BYTE_W-1:0]   third_byte;
  logic [lztd_pkg::BYTE_W-1:0]   fourth_byte;
  logic [lztd_pkg::CNT_W-1:0]    byte_count;
  logic                          last_of_run;
  logic                          error_flag;
  logic [lztd_pkg::TOTAL_W-1:0]  total_written;

  modport source (output valid, first_byte, second_byte, third_byte, fourth_byte,
                  byte_count, last_of_run, error_flag, total_written, input ready);
  modport sink (input valid, first_byte, second_byte, third_byte, fourth_byte,
                byte_count, last_of_run, error_flag, total_written, output ready);
endinterface

`default_nettype wire

@@ src/lztd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lztd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/lztd_ctrl.sv @@
// Token sequencer: history pointer, byte counter, copy loop and word grouping.
`default_nettype none

module lztd_ctrl #(
  parameter int unsigned WindowBytes = lztd_pkg::WINDOW_BYTES
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               tok_fire_i,
  input  wire logic                               tok_match_i,
  input  wire logic [lztd_pkg::BYTE_W-1:0]        tok_lit_i,
  input  wire logic [lztd_pkg::DIST_W-1:0]        tok_dist_i,
  input  wire logic [lztd_pkg::LEN_W-1:0]         tok_len_i,
  output logic                                    tok_ready_o,
  input  wire logic                               out_free_i,
  output logic                                    push_o,
  output lztd_pkg::res_t                          res_o,
  output logic                                    we_o,
  output logic      [$clog2(WindowBytes)-1:0]     waddr_o,
  output logic      [lztd_pkg::BYTE_W-1:0]        wdata_o,
  output logic                                    re_o,
  output logic      [$clog2(WindowBytes)-1:0]     raddr_o,
  input  wire logic [lztd_pkg::BYTE_W-1:0]        rdata_i
);

  localparam int unsigned AW = $clog2(WindowBytes);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic                                   state_q, state_d;
  logic [AW-1:0]                          wp_q, wp_d;
  logic [AW-1:0]                          rp_q, rp_d;
  logic [lztd_pkg::TOTAL_W-1:0]           bw_q, bw_d, bw_inc;
  logic                                   err_q, err_d;
  logic [lztd_pkg::DIST_W-1:0]            dist_q, dist_d;
  logic [lztd_pkg::LEN_W-1:0]             len_q, len_d;
  logic [lztd_pkg::LEN_W-1:0]             done_q, done_d;
  logic [lztd_pkg::SLOT_W-1:0]            slot_q, slot_d;
  logic [lztd_pkg::GROUP_BYTES-1:0][lztd_pkg::BYTE_W-1:0] grp_q, grp_d;
  logic [lztd_pkg::BYTE_W-1:0]            lastb_q, lastb_d;
  logic [lztd_pkg::BYTE_W-1:0]            cur_byte;
  logic                                   dist_bad, last_byte, grp_end;

  assign tok_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign bw_inc      = (bw_q == '1) ? bw_q : bw_q + 32'd1;
  assign dist_bad    = (tok_dist_i == '0) || (32'(tok_dist_i) > bw_q);
  // distance one reads the byte written in the same cycle: forward it
  assign cur_byte    = (dist_q == lztd_pkg::DIST_W'(1) && done_q != '0) ? lastb_q : rdata_i;
  assign last_byte   = (done_q == len_q - 8'd1);
  assign grp_end     = (slot_q == lztd_pkg::SLOT_W'(lztd_pkg::GROUP_BYTES - 1)) || last_byte;

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    bw_d    = bw_q;
    err_d   = err_q;
    dist_d  = dist_q;
    len_d   = len_q;
    done_d  = done_q;
    slot_d  = slot_q;
    grp_d   = grp_q;
    lastb_d = lastb_q;
    push_o  = 1'b0;
    res_o   = '0;
    we_o    = 1'b0;
    waddr_o = wp_q;
    wdata_o = tok_lit_i;
    re_o    = 1'b0;
    raddr_o = rp_q;

    case (state_q)
      ST_IDLE: begin
        if (tok_fire_i) begin
          push_o     = 1'b1;
          res_o.last = 1'b1;
          res_o.total = bw_q;
          if (err_q || (tok_match_i && dist_bad)) begin
            err_d     = 1'b1;
            res_o.err = 1'b1;
          end else if (!tok_match_i) begin
            we_o          = 1'b1;
            wp_d          = wp_q + AW'(1);
            bw_d          = bw_inc;
            lastb_d       = tok_lit_i;
            res_o.data[0] = tok_lit_i;
            res_o.count   = lztd_pkg::CNT_W'(1);
            res_o.total   = bw_inc;
          end else if (tok_len_i != '0) begin
            push_o  = 1'b0;
            re_o    = 1'b1;
            raddr_o = wp_q - AW'(tok_dist_i);
            rp_d    = wp_q - AW'(tok_dist_i) + AW'(1);
            dist_d  = tok_dist_i;
            len_d   = tok_len_i;
            done_d  = '0;
            slot_d  = '0;
            state_d = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (!grp_end || out_free_i) begin
          we_o          = 1'b1;
          wdata_o       = cur_byte;
          wp_d          = wp_q + AW'(1);
          bw_d          = bw_inc;
          lastb_d       = cur_byte;
          grp_d[slot_q] = cur_byte;
          done_d        = done_q + 8'd1;
          slot_d        = grp_end ? '0 : slot_q + lztd_pkg::SLOT_W'(1);
          if (!last_byte) begin
            re_o = 1'b1;
            rp_d = rp_q + AW'(1);
          end else begin
            state_d = ST_IDLE;
          end
          if (grp_end) begin
            push_o = 1'b1;
            for (int i = 0; i < lztd_pkg::GROUP_BYTES; i++) begin
              if (lztd_pkg::SLOT_W'(i) < slot_q) begin
                res_o.data[i] = grp_q[i];
              end else if (lztd_pkg::SLOT_W'(i) == slot_q) begin
                res_o.data[i] = cur_byte;
              end
            end
            res_o.count = lztd_pkg::CNT_W'(slot_q) + lztd_pkg::CNT_W'(1);
            res_o.last  = last_byte;
            res_o.total = bw_inc;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      bw_q    <= '0;
      err_q   <= 1'b0;
      done_q  <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      bw_q    <= bw_d;
      err_q   <= err_d;
      done_q  <= done_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q    <= rp_d;
    dist_q  <= dist_d;
    len_q   <= len_d;
    grp_q   <= grp_d;
    lastb_q <= lastb_d;
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("sticky error cleared");

  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.err |-> res_o.count == '0 && res_o.last) else $error("error word not empty");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY |-> done_q < len_q) else $error("copy ran past length");

  a_no_err_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY |-> !err_q) else $error("copy with error set");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> bw_q >= $past(bw_q)) else $error("byte count went down");

endmodule

`default_nettype wire

@@ src/lz77_token_decompressor.sv @@
// Top level: LZ77 token decompressor with history RAM and output word register.
//
//  channel | dir | handshake   | payload
//  tok_i   | in  | valid/ready | is_match, literal_byte, back_distance, copy_length
//  res_o   | out | valid/ready | four bytes, byte_count, last_of_run, error_flag, total_written
//
// Literal, error and zero-length tokens: the word lands in the output register as the token is taken.
// Match of L bytes: one history RAM read and one write per cycle while the copy loop is not stalled.
// The copy loop stalls at a group boundary while the output word is not taken.
// Reset clears pointer, byte count and error flag; no RAM clearing pass.
// A new token is taken only when the sequencer is idle and the output register is free.
`default_nettype none

module lz77_token_decompressor #(
  parameter int unsigned WindowBytes = lztd_pkg::WINDOW_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lztd_tok_if.sink   tok_i,
  lztd_res_if.source res_o
);

  localparam int unsigned AW = $clog2(WindowBytes);

  logic                          out_valid_q;
  lztd_pkg::res_t                res_q, res_d;
  logic                          out_free, push, tok_ready, tok_fire;
  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic [lztd_pkg::BYTE_W-1:0]   wdata, rdata;

  assign out_free    = !out_valid_q || res_o.ready;
  assign tok_i.ready = tok_ready;
  assign tok_fire    = tok_i.valid && tok_ready;

  lztd_ctrl #(.WindowBytes(WindowBytes)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_fire_i  (tok_fire),
    .tok_match_i (tok_i.is_match),
    .tok_lit_i   (tok_i.literal_byte),
    .tok_dist_i  (tok_i.back_distance),
    .tok_len_i   (tok_i.copy_length),
    .tok_ready_o (tok_ready),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res_d),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  lztd_ram #(.Width(lztd_pkg::BYTE_W), .Depth(WindowBytes)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.first_byte    = res_q.data[0];
  assign res_o.second_byte   = res_q.data[1];
  assign res_o.third_byte    = res_q.data[2];
  assign res_o.fourth_byte   = res_q.data[3];
  assign res_o.byte_count    = res_q.count;
  assign res_o.last_of_run   = res_q.last;
  assign res_o.error_flag    = res_q.err;
  assign res_o.total_written = res_q.total;

endmodule

`default_nettype wire

@@ sim/tb_lz77_token_decompressor.sv @@
// Testbench for the LZ77 token decompressor: random and directed tokens against a local decoder.
`default_nettype none

module tb_lz77_token_decompressor;

  localparam logic        TOK_LITERAL = 1'b0;
  localparam logic        TOK_MATCH   = 1'b1;
  localparam int unsigned MAX_DIST    = (1 << lztd_pkg::DIST_W) - 1;
  localparam int unsigned MAX_LEN     = (1 << lztd_pkg::LEN_W) - 1;

  logic clk_i;
  logic rst_ni;

  lztd_tok_if tok ();
  lztd_res_if res ();

  lz77_token_decompressor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .res_o  (res)
  );

  // decoder state
  logic [lztd_pkg::BYTE_W-1:0]  window_mem [lztd_pkg::WINDOW_BYTES];
  logic [lztd_pkg::DIST_W-1:0]  wr_ptr;
  logic [lztd_pkg::TOTAL_W-1:0] emitted;
  logic                         err_latched;
  lztd_pkg::res_t               pending_words [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned mismatches   = 0;
  int unsigned words_seen   = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #(64'd80_000_000);
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR: %s", msg);
  endtask

  function automatic void store_byte(input logic [lztd_pkg::BYTE_W-1:0] b);
    window_mem[wr_ptr] = b;
    wr_ptr++;
    if (emitted != '1) emitted++;
  endfunction

  task automatic decode_token(input logic m, input logic [lztd_pkg::BYTE_W-1:0] lit,
                              input logic [lztd_pkg::DIST_W-1:0] back_dist,
                              input logic [lztd_pkg::LEN_W-1:0] len);
    lztd_pkg::res_t              word;
    int unsigned                 done;
    logic [lztd_pkg::DIST_W-1:0] src;
    word      = '0;
    word.last = 1'b1;
    if (!err_latched && m == TOK_MATCH && (back_dist == 0 || back_dist > emitted))
      err_latched = 1'b1;
    if (err_latched) begin
      word.err   = 1'b1;
      word.total = emitted;
      pending_words.push_back(word);
    end else if (m == TOK_LITERAL) begin
      store_byte(lit);
      word.data[0] = lit;
      word.count   = lztd_pkg::CNT_W'(1);
      word.total   = emitted;
      pending_words.push_back(word);
    end else if (len == 0) begin
      word.total = emitted;
      pending_words.push_back(word);
    end else begin
      done = 0;
      while (done < len) begin
        word = '0;
        while (word.count < lztd_pkg::GROUP_BYTES && done < len) begin
          src = wr_ptr - back_dist;
          word.data[word.count] = window_mem[src];
          store_byte(window_mem[src]);
          word.count++;
          done++;
        end
        word.last  = (done == len);
        word.total = emitted;
        pending_words.push_back(word);
      end
    end
  endtask

  // entered and left at a falling edge
  task automatic send_token(input logic m, input logic [lztd_pkg::BYTE_W-1:0] lit,
                            input logic [lztd_pkg::DIST_W-1:0] back_dist,
                            input logic [lztd_pkg::LEN_W-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      tok.valid <= 1'b0;
      @(negedge clk_i);
    end
    tok.valid         <= 1'b1;
    tok.is_match      <= m;
    tok.literal_byte  <= lit;
    tok.back_distance <= back_dist;
    tok.copy_length   <= len;
    do @(posedge clk_i); while (!tok.ready);
    decode_token(m, lit, back_dist, len);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    tok.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_token(input int unsigned long_pct);
    logic [lztd_pkg::DIST_W-1:0] back_dist;
    logic [lztd_pkg::LEN_W-1:0]  len;
    int unsigned                 dmax;
    int unsigned                 pick;
    dmax = (emitted > MAX_DIST) ? MAX_DIST : emitted;
    if (dmax == 0 || $urandom_range(99) < 30) begin
      send_token(TOK_LITERAL, lztd_pkg::BYTE_W'($urandom), lztd_pkg::DIST_W'($urandom),
                 lztd_pkg::LEN_W'($urandom));
    end else begin
      // short distances give overlapping copies
      if ($urandom_range(99) < 40)
        back_dist = lztd_pkg::DIST_W'($urandom_range((dmax < 8) ? dmax : 8, 1));
      else back_dist = lztd_pkg::DIST_W'($urandom_range(dmax, 1));
      pick = $urandom_range(99);
      if (pick < 8) len = '0;
      else if (pick < 8 + long_pct) len = lztd_pkg::LEN_W'($urandom_range(MAX_LEN, 200));
      else if (pick < 60) len = lztd_pkg::LEN_W'($urandom_range(12, 1));
      else len = lztd_pkg::LEN_W'($urandom_range(64, 1));
      send_token(TOK_MATCH, lztd_pkg::BYTE_W'($urandom), back_dist, len);
    end
  endtask

  task automatic check_word();
    lztd_pkg::res_t got;
    lztd_pkg::res_t want;
    got.data[0] = res.first_byte;
    got.data[1] = res.second_byte;
    got.data[2] = res.third_byte;
    got.data[3] = res.fourth_byte;
    got.count   = res.byte_count;
    got.last    = res.last_of_run;
    got.err     = res.error_flag;
    got.total   = res.total_written;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
    end else begin
      want = pending_words.pop_front();
      for (int i = 0; i < lztd_pkg::GROUP_BYTES; i++)
        if (got.data[i] !== want.data[i])
          report_mismatch($sformatf("word %0d byte %0d: got %0h, expected %0h",
                                    words_seen, i, got.data[i], want.data[i]));
      if (got.count !== want.count)
        report_mismatch($sformatf("word %0d byte_count: got %0d, expected %0d",
                                  words_seen, got.count, want.count));
      if (got.last !== want.last)
        report_mismatch($sformatf("word %0d last_of_run: got %b, expected %b",
                                  words_seen, got.last, want.last));
      if (got.err !== want.err)
        report_mismatch($sformatf("word %0d error_flag: got %b, expected %b",
                                  words_seen, got.err, want.err));
      if (got.total !== want.total)
        report_mismatch($sformatf("word %0d total_written: got %0d, expected %0d",
                                  words_seen, got.total, want.total));
    end
    words_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) check_word();
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_token(TOK_LITERAL, 8'h00, '0, '0);
    send_token(TOK_LITERAL, 8'hFF, '0, '0);
    send_token(TOK_MATCH, 8'h00, 15'd1, 8'd1);
    send_token(TOK_MATCH, 8'h00, 15'd3, 8'd0);   // valid distance, empty copy
    send_token(TOK_MATCH, 8'h00, 15'd3, 8'd3);   // distance equal to bytes written
    send_token(TOK_LITERAL, 8'hA5, '1, '1);      // match fields ignored
    send_token(TOK_MATCH, 8'hFF, 15'd1, 8'd255); // longest run, overlapping
    send_token(TOK_MATCH, 8'h00, 15'd2, 8'd4);
    send_token(TOK_MATCH, 8'h00, 15'd5, 8'd5);
    send_token(TOK_MATCH, 8'h00, 15'd7, 8'd8);
    send_token(TOK_LITERAL, 8'h5A, '0, '0);
    send_token(TOK_MATCH, 8'h00, 15'd260, 8'd7);
    send_token(TOK_MATCH, 8'hFF, 15'd1, 8'd1);
    wait_drain();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned src_pct,
                             input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_random_token(20);
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left    = 300;
    send_token(TOK_MATCH, lztd_pkg::BYTE_W'($urandom),
               lztd_pkg::DIST_W'($urandom_range(200, 1)), 8'd255);
    send_token(TOK_LITERAL, lztd_pkg::BYTE_W'($urandom), '0, '0);
    send_token(TOK_MATCH, lztd_pkg::BYTE_W'($urandom), 15'd3, 8'd40);
    send_token(TOK_LITERAL, lztd_pkg::BYTE_W'($urandom), '0, '0);
    send_token(TOK_LITERAL, lztd_pkg::BYTE_W'($urandom), '0, '0);
    send_token(TOK_MATCH, lztd_pkg::BYTE_W'($urandom), 15'd1, 8'd0);
    wait_drain();
    src_idle_pct = 51;
    repeat (4) send_random_token(20);
    wait_drain();
  endtask

  task automatic test_window_extremes();
    src_idle_pct = 16;
    snk_idle_pct = 16;
    // fill past a full window with long copies
    while (emitted <= lztd_pkg::WINDOW_BYTES + 256)
      send_token(TOK_MATCH, lztd_pkg::BYTE_W'($urandom),
                 lztd_pkg::DIST_W'($urandom_range((emitted > MAX_DIST) ? MAX_DIST : emitted, 1)),
                 8'd255);
    send_token(TOK_MATCH, 8'h00, 15'h7FFF, 8'd255);
    send_token(TOK_MATCH, 8'h00, 15'h4000, 8'd4);
    send_token(TOK_MATCH, 8'h00, 15'h7FFF, 8'd1);
    send_token(TOK_LITERAL, 8'hC3, 15'h7FFF, 8'hFF);
    send_token(TOK_MATCH, 8'h00, 15'h7FFE, 8'd0);
    wait_drain();
  endtask

  // runs last: the error stays set until reset
  task automatic test_sticky_error();
    src_idle_pct = 16;
    snk_idle_pct = 16;
    send_token(TOK_LITERAL, 8'h3C, '0, '0);
    send_token(TOK_MATCH, 8'h00, 15'd0, 8'd0);   // zero distance, checked before length
    send_token(TOK_LITERAL, 8'hFF, '0, '0);
    send_token(TOK_MATCH, 8'h00, 15'd1, 8'd255);
    send_token(TOK_MATCH, 8'hFF, 15'h7FFF, 8'd255);
    send_token(TOK_MATCH, 8'h00, 15'd0, 8'd7);
    wait_drain();
  endtask

  initial begin
    rst_ni            = 1'b0;
    tok.valid         = 1'b0;
    tok.is_match      = 1'b0;
    tok.literal_byte  = '0;
    tok.back_distance = '0;
    tok.copy_length   = '0;
    res.ready         = 1'b0;
    wr_ptr            = '0;
    emitted           = '0;
    err_latched       = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(55, 0, 0);
    test_random(55, 51, 0);
    test_random(55, 0, 51);
    test_random(55, 16, 16);
    test_backpressure();
    test_window_extremes();
    test_sticky_error();

    repeat (16) @(negedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/lztd_pkg.sv
src/lztd_if.sv
src/lztd_ram.sv
src/lztd_ctrl.sv
src/lz77_token_decompressor.sv
sim/tb_lz77_token_decompressor.sv
